// ----- sv/fixed_partition_fit_allocator_assert.svh -----
// Assertion macros used by the allocator datapath.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_ASSERT_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FPFA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpfa: implication check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FPFA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpfa: next-cycle check failed");

`endif

// ----- sv/fpfa_pkg.sv -----
// Types, codes and constants of the fixed-partition fit allocator.
`default_nettype none

package fpfa_pkg;

  localparam int MAX_PARTITIONS = 64;
  localparam int SIZE_W         = 16;
  localparam int ADDR_W         = 38;
  localparam int FIRST_W        = 32;
  localparam int OUT_IDX_W      = 6;
  localparam int IDX_W          = $clog2(MAX_PARTITIONS);
  localparam int CNT_W          = $clog2(MAX_PARTITIONS + 1);
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_REQ   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_NOFIT = 2'd2
  } status_t;

  // Fit policies
  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_BEST  = 2'd1,
    MODE_WORST = 2'd2
  } fit_mode_t;

  // Register indexes
  typedef enum logic {
    REG_FIT_MODE   = 1'b0,
    REG_FIRST_ADDR = 1'b1
  } reg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_DRAIN,
    ST_FETCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SIZE_W-1:0] part_size;
    logic              preoccupied;
    logic [SIZE_W-1:0] req_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [OUT_IDX_W-1:0] partition_index;
    logic [ADDR_W-1:0]    start_address;
    logic [ADDR_W-1:0]    end_address;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_start;
    logic scan_step;
    logic fetch;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_req;
    logic scan_more;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/fpfa_ctrl.sv -----
// Sequencing state machine of the allocator.
`default_nettype none

module fpfa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire fpfa_pkg::dp_status_t sts,
  output fpfa_pkg::ctrl_cmd_t     cmd
);
  import fpfa_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (sts.is_req) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (sts.scan_more) begin
          cmd.scan_step = 1'b1;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      // last compare settles
      ST_DRAIN: begin
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/fpfa_datapath.sv -----
// Partition table, scan compare unit and result register of the allocator.
`default_nettype none

module fpfa_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire fpfa_pkg::ctrl_cmd_t                 cmd,
  output fpfa_pkg::dp_status_t                     sts,
  input  wire fpfa_pkg::in_item_t                  in_item,
  input  wire logic [1:0]                          fit_mode,
  input  wire logic [fpfa_pkg::FIRST_W-1:0]        first_address,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output fpfa_pkg::out_item_t                      out_item
);
  import fpfa_pkg::*;

  `include "fixed_partition_fit_allocator_assert.svh"

  // Table memories (contents undefined until loaded; an entry's occupied
  // mark is written when the entry is loaded, and only loaded entries are read)
  logic [SIZE_W-1:0] size_mem  [MAX_PARTITIONS];
  logic [ADDR_W-1:0] start_mem [MAX_PARTITIONS];
  logic              occ_mem   [MAX_PARTITIONS];

  logic [CNT_W-1:0]          count_r;
  logic [ADDR_W-1:0]         next_start_r;
  in_item_t                  item_r;

  // Scan state
  logic [CNT_W-1:0]  scan_idx_r;
  logic              rd_pend_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic [SIZE_W-1:0] size_rd_r;
  logic              occ_rd_r;
  logic              pick_found_r;
  logic [IDX_W-1:0]  pick_idx_r;
  logic [SIZE_W-1:0] pick_left_r;
  logic [ADDR_W-1:0] start_rd_r;

  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;

  logic              is_load, is_req, is_clear, table_full;
  logic              fits, take;
  logic [SIZE_W-1:0] left;
  logic [ADDR_W-1:0] load_start, load_end, grant_end;

  // Decode and address arithmetic
  always_comb begin
    is_load    = (item_r.kind == KIND_LOAD);
    is_req     = (item_r.kind == KIND_REQ);
    is_clear   = (item_r.kind == KIND_CLEAR);
    table_full = (count_r == CNT_W'(MAX_PARTITIONS));
    load_start = (count_r == '0) ? {{(ADDR_W-FIRST_W){1'b0}}, first_address}
                                 : next_start_r;
    load_end   = load_start + {{(ADDR_W-SIZE_W){1'b0}}, item_r.part_size};
    grant_end  = start_rd_r + {{(ADDR_W-SIZE_W){1'b0}}, item_r.req_size};
  end

  // Compare stage: one table entry per cycle
  always_comb begin
    left = size_rd_r - item_r.req_size;
    fits = rd_pend_r && !occ_rd_r && (size_rd_r >= item_r.req_size);
    take = fits && (!pick_found_r ||
                    ((fit_mode == MODE_BEST)  && (left < pick_left_r)) ||
                    ((fit_mode == MODE_WORST) && (left > pick_left_r)));
  end

  always_comb begin
    sts.is_req    = is_req;
    sts.scan_more = (scan_idx_r < count_r);
    sts.out_free  = !out_valid_r || out_ready;
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
  end

  // Memory writes on load and grant, registered reads for scan and fetch
  always_ff @(posedge clk) begin
    if (cmd.finish && is_load && !table_full) begin
      size_mem[count_r[IDX_W-1:0]]  <= item_r.part_size;
      start_mem[count_r[IDX_W-1:0]] <= load_start;
      occ_mem[count_r[IDX_W-1:0]]   <= item_r.preoccupied;
    end else if (cmd.finish && is_req && pick_found_r) begin
      occ_mem[pick_idx_r] <= 1'b1;
    end
    if (cmd.scan_step) begin
      size_rd_r <= size_mem[scan_idx_r[IDX_W-1:0]];
      occ_rd_r  <= occ_mem[scan_idx_r[IDX_W-1:0]];
      rd_idx_r  <= scan_idx_r[IDX_W-1:0];
    end
    if (cmd.fetch) begin
      start_rd_r <= start_mem[pick_idx_r];
    end
  end

  // Scan pointer and running pick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r   <= '0;
      rd_pend_r    <= 1'b0;
      pick_found_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.scan_step;
      if (cmd.scan_start) begin
        scan_idx_r   <= '0;
        pick_found_r <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
        if (take) begin
          pick_found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pick_idx_r  <= rd_idx_r;
      pick_left_r <= left;
    end
  end

  // Table state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      next_start_r <= '0;
    end else if (cmd.finish) begin
      if (is_load && !table_full) begin
        count_r      <= count_r + 1'b1;
        next_start_r <= load_end;
      end else if (is_clear) begin
        count_r      <= '0;
        next_start_r <= '0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result fields; unused fields stay zero
  always_comb begin
    out_item_nxt = '0;
    if (is_load) begin
      if (table_full) begin
        out_item_nxt.status = STAT_FULL;
      end else begin
        out_item_nxt.status          = STAT_OK;
        out_item_nxt.partition_index = OUT_IDX_W'(count_r);
        out_item_nxt.start_address   = load_start;
        out_item_nxt.end_address     = load_end;
      end
    end else if (is_req) begin
      if (pick_found_r) begin
        out_item_nxt.status          = STAT_OK;
        out_item_nxt.partition_index = OUT_IDX_W'(pick_idx_r);
        out_item_nxt.start_address   = start_rd_r;
        out_item_nxt.end_address     = grant_end;
      end else begin
        out_item_nxt.status = STAT_NOFIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  `FPFA_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_PARTITIONS))
  `FPFA_ASSERT_IMP(a_finish_slot_free, cmd.finish, !out_valid_r || out_ready)
  `FPFA_ASSERT_NXT(a_finish_shows_result, cmd.finish, out_valid_r)
  `FPFA_ASSERT_IMP(a_pick_in_table, cmd.finish && is_req && pick_found_r, CNT_W'(pick_idx_r) < count_r)

endmodule

`default_nettype wire

// ----- sv/fixed_partition_fit_allocator.sv -----
// Top level of the fixed-partition fit allocator: config registers and wiring.
//
// Usage: items enter on in_valid/in_ready with payload in_item, results leave on
// out_valid/out_ready with payload out_item; every item yields exactly one result.
// A load item appends a partition, a request item grants a free partition by the
// fit_mode policy, a clear item empties the table.
// A load, clear or unused-kind item passes the decide and finish states on its
// way to the result register; a request passes decide, scan, drain, fetch and
// finish, as the scan reads the size table memory one entry per cycle through
// one compare unit over the loaded partitions, then reads the start table.
// One item is in work at a time; in_ready is high only while the block is idle, so
// a new item is taken only after the last one is written to the result register.
// The result register parts the two sides: a new item is accepted while the last
// result still waits; a stalled receiver only holds the block at the point where
// the next result must be written.
// Reset (synchronous, rst_n low) empties the table, sets fit_mode to first fit and
// first_address to zero, and drops out_valid.
// APB port: fit_mode at byte 0, first_address at byte 4; write only when idle.
`default_nettype none

module fixed_partition_fit_allocator (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire fpfa_pkg::in_item_t            in_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output fpfa_pkg::out_item_t                out_item,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fpfa_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [fpfa_pkg::PDATA_W-1:0]  pwdata,
  output logic [fpfa_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);
  import fpfa_pkg::*;

  logic [1:0]         fit_mode_r;
  logic [FIRST_W-1:0] first_address_r;
  logic               reg_wr;
  reg_idx_t           reg_sel;
  ctrl_cmd_t          cmd;
  dp_status_t         sts;

  // Register decode: one 32-bit word per register
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r      <= MODE_FIRST;
      first_address_r <= '0;
    end else if (reg_wr) begin
      unique case (reg_sel)
        REG_FIT_MODE:   fit_mode_r      <= pwdata[1:0];
        REG_FIRST_ADDR: first_address_r <= pwdata[FIRST_W-1:0];
        default:        fit_mode_r      <= fit_mode_r;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      REG_FIT_MODE:   prdata = {{(PDATA_W-2){1'b0}}, fit_mode_r};
      REG_FIRST_ADDR: prdata = first_address_r;
      default:        prdata = '0;
    endcase
  end

  fpfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fpfa_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_item       (in_item),
    .fit_mode      (fit_mode_r),
    .first_address (first_address_r),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item)
  );

endmodule

`default_nettype wire

// ----- tb/alloc_check_pkg.sv -----
// Scoreboard class for the partition allocator: predicts each result and checks it in order.
`timescale 1ns / 100ps

package alloc_check_pkg;
  import fpfa_pkg::*;

  // Codes the block must tolerate but the package does not name
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  class alloc_scoreboard;
    // Predicted allocator state
    logic [SIZE_W-1:0]  size_tab  [MAX_PARTITIONS];
    logic [ADDR_W-1:0]  start_tab [MAX_PARTITIONS];
    bit                 occupied  [MAX_PARTITIONS];
    int unsigned        part_count;
    logic [ADDR_W-1:0]  next_start;
    logic [1:0]         mode;
    logic [FIRST_W-1:0] first_addr;

    // Results still owed by the block, oldest first
    out_item_t   owed_q[$];
    int unsigned errors, checked, grants, no_fits, fulls;

    function new();
      mode       = MODE_FIRST;
      first_addr = '0;
      part_count = 0;
      next_start = '0;
      foreach (occupied[i]) occupied[i] = 1'b0;
      errors  = 0;
      checked = 0;
      grants  = 0;
      no_fits = 0;
      fulls   = 0;
    endfunction

    function void set_register(reg_idx_t r, logic [PDATA_W-1:0] v);
      if (r == REG_FIT_MODE) begin
        mode = v[1:0];
      end else begin
        first_addr = v[FIRST_W-1:0];
      end
    endfunction

    // Index of the free partition chosen by the current policy, -1 if none fits
    function int find_fit(logic [SIZE_W-1:0] req);
      int pick;
      logic [SIZE_W-1:0] left, pick_left;
      pick = -1;
      pick_left = '0;
      for (int i = 0; i < part_count; i++) begin
        if (occupied[i] || size_tab[i] < req) continue;
        left = size_tab[i] - req;
        if (pick < 0) begin
          pick = i;
          pick_left = left;
          // first fit, and the spare mode code, stop at the first hit
          if (mode != MODE_BEST && mode != MODE_WORST) break;
        end else if (mode == MODE_BEST && left < pick_left) begin
          pick = i;
          pick_left = left;
        end else if (mode == MODE_WORST && left > pick_left) begin
          pick = i;
          pick_left = left;
        end
      end
      return pick;
    endfunction

    // Called for every accepted item: update state, queue the result it owes
    function void note_item(in_item_t it);
      out_item_t owed;
      logic [ADDR_W-1:0] st;
      int pick;
      owed = '0;
      owed.status = STAT_OK;
      case (it.kind)
        KIND_LOAD: begin
          if (part_count >= MAX_PARTITIONS) begin
            owed.status = STAT_FULL;
            fulls++;
          end else begin
            // partition zero takes the register value at the time it is loaded
            st = (part_count == 0) ? ADDR_W'(first_addr) : next_start;
            size_tab[part_count]  = it.part_size;
            start_tab[part_count] = st;
            occupied[part_count]  = it.preoccupied;
            next_start = st + ADDR_W'(it.part_size);
            owed.partition_index = OUT_IDX_W'(part_count);
            owed.start_address   = st;
            owed.end_address     = next_start;
            part_count++;
          end
        end
        KIND_REQ: begin
          pick = find_fit(it.req_size);
          if (pick < 0) begin
            owed.status = STAT_NOFIT;
            no_fits++;
          end else begin
            occupied[pick] = 1'b1;
            owed.partition_index = OUT_IDX_W'(pick);
            owed.start_address   = start_tab[pick];
            owed.end_address     = start_tab[pick] + ADDR_W'(it.req_size);
            grants++;
          end
        end
        KIND_CLEAR: begin
          part_count = 0;
          next_start = '0;
          foreach (occupied[i]) occupied[i] = 1'b0;
        end
        default: ;
      endcase
      owed_q.push_back(owed);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Called for every accepted result
    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_q.size() == 0) begin
        $error("result 0x%0h arrived with no item outstanding", got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      checked++;
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("partition_index", 64'(want.partition_index), 64'(got.partition_index));
      compare_field("start_address", 64'(want.start_address), 64'(got.start_address));
      compare_field("end_address", 64'(want.end_address), 64'(got.end_address));
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

endpackage

// ----- tb/testbench.sv -----
// Top-level testbench of the partition allocator: stimulus, APB setup, handshakes, checking.
`timescale 1ns / 100ps

module testbench;
  import fpfa_pkg::*;
  import alloc_check_pkg::*;

  localparam int RUN_PHASES  = 8;
  localparam int PHASE_ITEMS = 210;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 80;

  localparam logic [1:0] MODE_SEL [4] = '{MODE_FIRST, MODE_BEST, MODE_WORST, MODE_UNUSED};

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_item;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  alloc_scoreboard sb;
  int send_idle  = 0;
  int recv_stall = 0;
  int hold_asks  = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int items_sent = 0;

  fixed_partition_fit_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #60_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off when one is asked for
  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
  end

  function automatic in_item_t pack_item(logic [1:0] kind, logic [SIZE_W-1:0] psize,
                                         logic pre, logic [SIZE_W-1:0] rsize);
    in_item_t it;
    it.kind        = kind;
    it.part_size   = psize;
    it.preoccupied = pre;
    it.req_size    = rsize;
    return it;
  endfunction

  // Mostly small sizes so requests often fit; now and then zero or anything
  function automatic logic [SIZE_W-1:0] rand_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return SIZE_W'($urandom);
    if (r < 12) return '0;
    return SIZE_W'($urandom_range(1, 300));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with in_valid still high, so a back-to-back item needs no re-raise.
  task automatic send_item(input in_item_t it);
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    if (it.kind != KIND_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  // Sender pauses until every owed result is back, then the block is idle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_register(input reg_idx_t r, input logic [PDATA_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(r));
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (pready) sb.set_register(r, v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_load(input logic [SIZE_W-1:0] sz, input logic pre);
    send_item(pack_item(KIND_LOAD, sz, pre, SIZE_W'($urandom)));
  endtask

  task automatic send_req(input logic [SIZE_W-1:0] sz);
    send_item(pack_item(KIND_REQ, SIZE_W'($urandom), 1'($urandom), sz));
  endtask

  task automatic send_clear();
    send_item(pack_item(KIND_CLEAR, SIZE_W'($urandom), 1'($urandom), SIZE_W'($urandom)));
  endtask

  // Hand-picked opener: empty table, size extremes, ties in best and worst fit
  task automatic run_directed();
    write_register(REG_FIT_MODE, PDATA_W'(MODE_FIRST));
    write_register(REG_FIRST_ADDR, 32'h0000_1000);
    send_req(16'd5);
    send_load(16'd0, 1'b0);
    send_load(16'hFFFF, 1'b0);
    send_load(16'd100, 1'b1);
    send_load(16'd40, 1'b0);
    send_req(16'd0);
    send_req(16'hFFFF);
    send_req(16'd30);
    send_req(16'd1);
    send_item(pack_item(KIND_UNUSED, 16'hFFFF, 1'b1, 16'hFFFF));
    send_clear();
    send_req(16'd0);
    wait_idle();

    // best fit, partitions straddling the 32-bit boundary
    write_register(REG_FIT_MODE, PDATA_W'(MODE_BEST));
    write_register(REG_FIRST_ADDR, 32'hFFFF_FFFF);
    send_load(16'd50, 1'b0);
    send_load(16'd20, 1'b0);
    send_load(16'd30, 1'b0);
    send_load(16'd20, 1'b0);
    send_req(16'd18);
    send_req(16'd18);
    send_req(16'd10);
    wait_idle();

    // worst fit with a tie, then the spare mode code
    write_register(REG_FIT_MODE, PDATA_W'(MODE_WORST));
    write_register(REG_FIRST_ADDR, 32'h0);
    send_clear();
    send_load(16'd10, 1'b0);
    send_load(16'd70, 1'b0);
    send_load(16'd70, 1'b0);
    send_load(16'd5, 1'b0);
    send_req(16'd5);
    send_req(16'd5);
    wait_idle();
    write_register(REG_FIT_MODE, PDATA_W'(MODE_UNUSED));
    send_req(16'd1);
    send_req(16'hFFFF);
    wait_idle();
  endtask

  // One table life: clear, fill, then mostly requests with some loads and noise
  task automatic run_episode();
    int n_loads, n_reqs, r;
    n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(62, 70) : $urandom_range(1, 16);
    n_reqs  = $urandom_range(1, 20);
    send_clear();
    repeat (n_loads) send_load(rand_size(), ($urandom_range(0, 99) < 20));
    repeat (n_reqs) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_load(rand_size(), 1'($urandom));
      end else if (r < 13) begin
        send_item(pack_item(KIND_UNUSED, SIZE_W'($urandom), 1'($urandom),
                            SIZE_W'($urandom)));
      end else begin
        send_req(rand_size());
      end
    end
  endtask

  initial begin
    int phase_start;
    logic [PDATA_W-1:0] base;
    sb = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    out_ready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();

    for (int ph = 0; ph < RUN_PHASES; ph++) begin
      wait_idle();
      // idle profile: none, sender idle, receiver stalling, both
      case ((ph + ph / 4) % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 87; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 87; end
        default: begin send_idle = 36; recv_stall = 36; end
      endcase
      case ((ph / 2) % 4)
        0: base = 32'h0;
        1: base = 32'hFFFF_FFFF;
        2: base = $urandom;
        default: base = 32'hFFFF_0000;
      endcase
      write_register(REG_FIT_MODE, PDATA_W'(MODE_SEL[ph % 4]));
      write_register(REG_FIRST_ADDR, base);
      // long receiver hold-off while items keep coming
      @(posedge clk);
      hold_asks++;
      @(negedge clk);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) run_episode();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d items (%0d results checked): directed opener plus %0d random phases",
             items_sent, sb.checked, RUN_PHASES);
    $display("over all four mode codes; %0d grants, %0d no-fit, %0d loads into a full table.",
             sb.grants, sb.no_fits, sb.fulls);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/fpfa_pkg.sv
sv/fpfa_ctrl.sv
sv/fpfa_datapath.sv
sv/fixed_partition_fit_allocator.sv
tb/alloc_check_pkg.sv
tb/testbench.sv
